// ===== rtl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== rtl/mnp_pkg.sv =====
`default_nettype none
package mnp_pkg;

  localparam int NumKeys = 128;
  localparam int KeyW    = $clog2(NumKeys);

  // message kinds, high nibble of the status byte
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  // timestamp modes
  localparam logic [1:0] MODE_FRAMES = 2'd0;
  localparam logic [1:0] MODE_MILLIS = 2'd1;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RATE   = 2'd2;

  localparam logic [18:0] RATE_RESET = 19'd48000;

  typedef struct packed {
    logic [3:0]      chan;
    logic [3:0]      kind;
    logic [KeyW-1:0] key;
    logic [6:0]      vel;
    logic [31:0]     ts;
    logic [1:0]      mode;
    logic            last;
    logic            neg;
  } meta_t;

endpackage
`default_nettype wire

// ===== rtl/mnp_conv.sv =====
`default_nettype none
module mnp_conv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_vld_i,
  input  mnp_pkg::meta_t      in_meta_i,
  input  logic [31:0]         time_offset_i,
  input  logic [18:0]         sample_rate_i,
  output logic                out_vld_o,
  output mnp_pkg::meta_t      out_meta_o,
  output logic [31:0]         out_pos_o
);
  import mnp_pkg::*;

  localparam int NumStg = 8;
  localparam int DivShift = 37;
  // ceil(2^37 / 1000), exact quotient for any 27-bit dividend
  localparam logic [27:0] Recip = 28'd137438954;
  localparam logic [26:0] Divisor = 27'd1000;

  function automatic logic [16:0] div_quot(input logic [26:0] x);
    logic [54:0] prod;
    prod = 55'(x) * 55'(Recip);
    return prod[DivShift+16:DivShift];
  endfunction

  function automatic logic [9:0] div_rem(input logic [26:0] x, input logic [16:0] q);
    logic [26:0] r;
    r = x - 27'(q) * Divisor;
    return r[9:0];
  endfunction

  logic [NumStg-1:0] vld_q;
  meta_t             meta_q [NumStg];

  logic [32:0] diff;
  logic [32:0] mag;
  meta_t       meta0_d;

  logic [31:0] m0_q;
  logic [18:0] sr0_q;
  logic [50:0] p1_q;
  logic [26:0] x2_q;
  logic [16:0] q2_q;
  logic [33:0] plo2_q;
  logic [9:0]  r3_q;
  logic [16:0] q2s3_q;
  logic [33:0] plo3_q;
  logic [26:0] x4_q;
  logic [16:0] q1_q;
  logic [16:0] q2s4_q;
  logic [16:0] c0s4_q;
  logic [9:0]  r5_q;
  logic [16:0] q2s5_q;
  logic [16:0] q1s5_q;
  logic [16:0] c0s5_q;
  logic [50:0] q6_q;
  logic [31:0] pos7_q;

  logic [26:0] x2_d;
  logic [26:0] x4_d;
  logic [26:0] x6_d;
  logic [31:0] sat_d;
  logic [31:0] pos_d;

  // millisecond offset removed, magnitude kept with a sign flag
  assign diff = {in_meta_i.ts[31], in_meta_i.ts} - {time_offset_i[31], time_offset_i};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;

  always_comb begin
    meta0_d     = in_meta_i;
    meta0_d.neg = diff[32];
  end

  // long division by 1000 in three 17-bit chunks
  assign x2_d = {10'd0, p1_q[50:34]};
  assign x4_d = {r3_q, plo3_q[33:17]};
  assign x6_d = {r5_q, c0s5_q};

  always_comb begin
    if (meta_q[6].neg) begin
      sat_d = (q6_q > 51'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - q6_q[31:0]);
    end else begin
      sat_d = (q6_q > 51'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q6_q[31:0];
    end
    pos_d = (meta_q[6].mode == MODE_FRAMES) ? meta_q[6].ts : sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStg-2:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta0_d;
      for (int i = 1; i < NumStg; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      m0_q   <= mag[31:0];
      sr0_q  <= sample_rate_i;
      p1_q   <= 51'(m0_q) * 51'(sr0_q);
      x2_q   <= x2_d;
      q2_q   <= div_quot(x2_d);
      plo2_q <= p1_q[33:0];
      r3_q   <= div_rem(x2_q, q2_q);
      q2s3_q <= q2_q;
      plo3_q <= plo2_q;
      x4_q   <= x4_d;
      q1_q   <= div_quot(x4_d);
      q2s4_q <= q2s3_q;
      c0s4_q <= plo3_q[16:0];
      r5_q   <= div_rem(x4_q, q1_q);
      q2s5_q <= q2s4_q;
      q1s5_q <= q1_q;
      c0s5_q <= c0s4_q;
      q6_q   <= {q2s5_q, q1s5_q, div_quot(x6_d)};
      pos7_q <= pos_d;
    end
  end

  assign out_vld_o  = vld_q[NumStg-1];
  assign out_meta_o = meta_q[NumStg-1];
  assign out_pos_o  = pos7_q;

endmodule
`default_nettype wire

// ===== rtl/mnp_table.sv =====
`default_nettype none
`include "assert_macros.svh"
module mnp_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_vld_i,
  input  mnp_pkg::meta_t      in_meta_i,
  input  logic [31:0]         in_pos_i,
  output logic                out_vld_o,
  output logic [3:0]          out_channel_o,
  output logic [6:0]          out_key_o,
  output logic [6:0]          out_velocity_o,
  output logic [31:0]         onset_pos_o,
  output logic [31:0]         end_pos_o
);
  import mnp_pkg::*;

  logic [NumKeys-1:0] open_q;
  logic [38:0]        mem [NumKeys];
  logic [38:0]        rd_q;
  logic               out_vld_q;
  logic [3:0]         chan_q;
  logic [KeyW-1:0]    key_q;
  logic [31:0]        end_q;

  logic mode_ok;
  logic act;
  logic wr_en;
  logic rd_en;

  assign mode_ok = (in_meta_i.mode == MODE_FRAMES) || (in_meta_i.mode == MODE_MILLIS);
  assign act     = in_vld_i && mode_ok;
  assign wr_en   = act && (in_meta_i.kind == KIND_NOTE_ON);
  assign rd_en   = act && (in_meta_i.kind == KIND_NOTE_OFF) && open_q[in_meta_i.key];

  // open flags live in flops so a batch end clears them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= rd_en;
      if (in_vld_i && in_meta_i.last) begin
        open_q <= '0;
      end else if (wr_en) begin
        open_q[in_meta_i.key] <= 1'b1;
      end else if (rd_en) begin
        open_q[in_meta_i.key] <= 1'b0;
      end
    end
  end

  // velocity and start position, one port each way; reads and writes
  // come from the same stage so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (en_i && wr_en) begin
      mem[in_meta_i.key] <= {in_meta_i.vel, in_pos_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && rd_en) begin
      rd_q   <= mem[in_meta_i.key];
      chan_q <= in_meta_i.chan;
      key_q  <= in_meta_i.key;
      end_q  <= in_pos_i;
    end
  end

  assign out_vld_o      = out_vld_q;
  assign out_channel_o  = chan_q;
  assign out_key_o      = key_q;
  assign out_velocity_o = rd_q[38:32];
  assign onset_pos_o    = rd_q[31:0];
  assign end_pos_o      = end_q;

  `ASSERT_PROP(a_batch_clears, clk_i, rst_ni, (en_i && in_vld_i && in_meta_i.last) |=> (open_q == '0))
  `ASSERT_PROP(a_hit_closes, clk_i, rst_ni, (en_i && rd_en) |=> (open_q[key_q] == 1'b0))
  `ASSERT_PROP(a_on_opens, clk_i, rst_ni, (en_i && wr_en && !in_meta_i.last) |=> open_q[$past(in_meta_i.key)])
  `ASSERT_NEVER(a_rd_wr_excl, clk_i, rst_ni, wr_en && rd_en)

endmodule
`default_nettype wire

// ===== rtl/midi_note_on_off_pairing.sv =====
// channel  dir  fields (lsb first)
// s_axis   in   tdata: status_byte, data_one, data_two, time_stamp; tlast: last_in_batch
// m_axis   out  tdata: out_channel, out_key, out_velocity, onset_pos, end_pos
// cfg      in   write only: timestamp_mode, time_offset, sample_rate
//
// one request per cycle sustained while the output register is empty or taken; each
// request passes the millisecond conversion (one multiply and a three-chunk divide by
// 1000) ahead of the key table read-modify-write
// the whole pipeline advances whenever the output register is empty or taken
// asynchronous active-low reset clears the open-key flags, no memory sweep
`default_nettype none
module midi_note_on_off_pairing (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // status_byte[7:0], data_one[14:8], data_two[21:15], time_stamp[53:22], zero pad
  input  logic [55:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_channel[3:0], out_key[10:4], out_velocity[17:11], onset_pos[49:18],
  // end_pos[81:50], zero pad
  output logic [87:0]                 m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [mnp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i
);
  import mnp_pkg::*;

  logic [1:0]  mode_q;
  logic [31:0] offset_q;
  logic [18:0] rate_q;

  logic  en;
  logic  in_acc;
  meta_t in_meta;

  logic  cv_vld;
  meta_t cv_meta;
  logic [31:0] cv_pos;

  logic [3:0]  o_chan;
  logic [6:0]  o_key;
  logic [6:0]  o_vel;
  logic [31:0] o_start;
  logic [31:0] o_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_FRAMES;
      offset_q <= '0;
      rate_q   <= RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_OFFSET: offset_q <= cfg_data_i;
        REG_RATE:   rate_q   <= cfg_data_i[18:0];
        default:    ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  always_comb begin
    in_meta.chan = s_axis_tdata[3:0];
    in_meta.kind = s_axis_tdata[7:4];
    in_meta.key  = s_axis_tdata[14:8];
    in_meta.vel  = s_axis_tdata[21:15];
    in_meta.ts   = s_axis_tdata[53:22];
    in_meta.mode = mode_q;
    in_meta.last = s_axis_tlast;
    in_meta.neg  = 1'b0;
  end

  mnp_conv u_conv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_vld_i      (in_acc),
    .in_meta_i     (in_meta),
    .time_offset_i (offset_q),
    .sample_rate_i (rate_q),
    .out_vld_o     (cv_vld),
    .out_meta_o    (cv_meta),
    .out_pos_o     (cv_pos)
  );

  mnp_table u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .in_vld_i       (cv_vld),
    .in_meta_i      (cv_meta),
    .in_pos_i       (cv_pos),
    .out_vld_o      (m_axis_tvalid),
    .out_channel_o  (o_chan),
    .out_key_o      (o_key),
    .out_velocity_o (o_vel),
    .onset_pos_o    (o_start),
    .end_pos_o      (o_end)
  );

  assign m_axis_tdata = {6'd0, o_end, o_start, o_vel, o_key, o_chan};

endmodule
`default_nettype wire
